@@ rtl/aes128_ctr_payload_cipher_unit_assert.svh @@
// Assertion macros shared by the cipher unit checker.
`ifndef AES128_CTR_PAYLOAD_CIPHER_UNIT_ASSERT_SVH
`define AES128_CTR_PAYLOAD_CIPHER_UNIT_ASSERT_SVH
// Clocked assertion, disabled while reset is high.
`define ACPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define ACPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/acpc_pkg.sv @@
// Types, tables and AES round functions for the CTR payload cipher.
`default_nettype none
package acpc_pkg;
   typedef logic [15:0][7:0] aes_block_type;   // byte i sits at [15-i]

   localparam int unsigned CSR_KEY_HIGH   = 0;
   localparam int unsigned CSR_KEY_LOW    = 1;
   localparam int unsigned CSR_NETWORK_ID = 2;
   localparam int unsigned CSR_SALT       = 3;
   localparam logic [3:0]  LAST_ROUND     = 4'd10;

   localparam logic [7:0] SBOX_TABLE [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] rcon_of(input logic [3:0] rnd);
      logic [7:0] v;
      case (rnd)
         4'd1:    v = 8'h01;
         4'd2:    v = 8'h02;
         4'd3:    v = 8'h04;
         4'd4:    v = 8'h08;
         4'd5:    v = 8'h10;
         4'd6:    v = 8'h20;
         4'd7:    v = 8'h40;
         4'd8:    v = 8'h80;
         4'd9:    v = 8'h1b;
         4'd10:   v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Next round key from the current one.
   function automatic aes_block_type next_round_key(input aes_block_type rk,
                                                   input logic [3:0] rnd);
      aes_block_type nk;
      logic [3:0][7:0] t;
      t[3] = SBOX_TABLE[rk[2]] ^ rcon_of(rnd);
      t[2] = SBOX_TABLE[rk[1]];
      t[1] = SBOX_TABLE[rk[0]];
      t[0] = SBOX_TABLE[rk[3]];
      for (int j = 0; j < 4; j++) begin
         nk[15-j] = rk[15-j] ^ t[3-j];
         nk[11-j] = rk[11-j] ^ nk[15-j];
         nk[7-j]  = rk[7-j]  ^ nk[11-j];
         nk[3-j]  = rk[3-j]  ^ nk[7-j];
      end
      return nk;
   endfunction

   // SubBytes, ShiftRows and, except in the final round, MixColumns.
   function automatic aes_block_type round_core(input aes_block_type st,
                                               input logic final_rnd);
      aes_block_type s;
      aes_block_type t;
      aes_block_type m;
      logic [7:0] a0, a1, a2, a3;
      for (int i = 0; i < 16; i++) s[15-i] = SBOX_TABLE[st[15-i]];
      for (int i = 0; i < 16; i++) t[15-i] = s[15-((((i >> 2) + (i & 3)) & 3) * 4 + (i & 3))];
      for (int c = 0; c < 4; c++) begin
         a0 = t[15-4*c];
         a1 = t[14-4*c];
         a2 = t[13-4*c];
         a3 = t[12-4*c];
         m[15-4*c] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         m[14-4*c] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         m[13-4*c] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         m[12-4*c] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return final_rnd ? t : m;
   endfunction
endpackage
`default_nettype wire

@@ rtl/aes128_ctr_payload_cipher_unit.sv @@
// AES-128 CTR payload cipher: one byte in, one byte out.
// A byte that opens a 16-byte block is whitened with the key at accept, then makes ten
//   passes through the shared round unit with on-the-fly key expansion; other bytes use
//   the stored keystream. A new byte is taken only when no rounds run and no result waits.
// Reset (synchronous, active high): clears frame state, counters, handshake and CSRs;
//   the keystream register is written at each block start before it is used.
`default_nettype none
module aes128_ctr_payload_cipher_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [7:0]  req_source_node,
   input  wire logic [15:0] req_sequence_req,
   input  wire logic        req_last_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_out_last,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   typedef enum logic {ST_IDLE, ST_ROUND} fsm_type;

   fsm_type              fsm_ff;
   logic [63:0]          key_high_ff, key_low_ff;
   logic [7:0]           network_id_ff;
   logic [23:0]          salt_ff;
   logic                 in_frame_ff;
   logic [3:0]           offset_ff;
   logic [23:0]          blk_cnt_ff;
   logic [7:0]           src_ff;
   logic [15:0]          seq_ff;
   logic [7:0]           data_ff;
   logic                 last_ff;
   logic [3:0]           round_ff;
   acpc_pkg::aes_block_type state_ff, rk_ff, ks_ff;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_byte_ff;
   logic                 rsp_last_ff;

   // Frame context seen by the byte at the request port.
   logic [7:0]           cur_src_in;
   logic [15:0]          cur_seq_in;
   logic [23:0]          cur_cnt_in;
   logic [3:0]           cur_off_in;
   acpc_pkg::aes_block_type key_in, ctr_blk_in, rk_next_in, round_out_in;
   logic                 accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (fsm_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   always_comb begin
      cur_src_in = in_frame_ff ? src_ff : req_source_node;
      cur_seq_in = in_frame_ff ? seq_ff : req_sequence_req;
      cur_cnt_in = in_frame_ff ? blk_cnt_ff : 24'd0;
      cur_off_in = in_frame_ff ? offset_ff : 4'd0;
      key_in     = {key_high_ff, key_low_ff};
      ctr_blk_in = {cur_src_in, network_id_ff, cur_seq_in[7:0], cur_seq_in[15:8],
                    salt_ff, 48'd0, cur_cnt_in};
      rk_next_in   = acpc_pkg::next_round_key(rk_ff, round_ff);
      round_out_in = acpc_pkg::round_core(state_ff, round_ff == acpc_pkg::LAST_ROUND)
                     ^ rk_next_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= ST_IDLE;
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         network_id_ff <= '0;
         salt_ff       <= '0;
         in_frame_ff   <= 1'b0;
         offset_ff     <= '0;
         blk_cnt_ff    <= '0;
         src_ff        <= '0;
         seq_ff        <= '0;
         round_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               2'(acpc_pkg::CSR_KEY_HIGH):   key_high_ff   <= csr_wdata;
               2'(acpc_pkg::CSR_KEY_LOW):    key_low_ff    <= csr_wdata;
               2'(acpc_pkg::CSR_NETWORK_ID): network_id_ff <= csr_wdata[7:0];
               2'(acpc_pkg::CSR_SALT):       salt_ff       <= csr_wdata[23:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (fsm_ff)
            ST_IDLE: begin
               if (accept) begin
                  data_ff <= req_data_byte;
                  last_ff <= req_last_byte;
                  src_ff  <= cur_src_in;
                  seq_ff  <= cur_seq_in;
                  // advance frame position now; the block start keeps its own copy
                  if (req_last_byte) begin
                     in_frame_ff <= 1'b0;
                     offset_ff   <= '0;
                     blk_cnt_ff  <= '0;
                  end else begin
                     in_frame_ff <= 1'b1;
                     offset_ff   <= cur_off_in + 4'd1;
                     blk_cnt_ff  <= (cur_off_in == 4'd15) ? cur_cnt_in + 24'd1 : cur_cnt_in;
                  end
                  if (cur_off_in == 4'd0) begin
                     state_ff <= ctr_blk_in ^ key_in;
                     rk_ff    <= key_in;
                     round_ff <= 4'd1;
                     fsm_ff   <= ST_ROUND;
                  end else begin
                     rsp_byte_ff  <= req_data_byte ^ ks_ff[4'(4'd15 - cur_off_in)];
                     rsp_last_ff  <= req_last_byte;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_ROUND: begin
               state_ff <= round_out_in;
               rk_ff    <= rk_next_in;
               round_ff <= round_ff + 4'd1;
               if (round_ff == acpc_pkg::LAST_ROUND) begin
                  ks_ff        <= round_out_in;
                  rsp_byte_ff  <= data_ff ^ round_out_in[15];
                  rsp_last_ff  <= last_ff;
                  rsp_valid_ff <= 1'b1;
                  fsm_ff       <= ST_IDLE;
               end
            end
            default: fsm_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/acpc_checker.sv @@
// Port-level checker for the CTR payload cipher, bound to the top level.
`default_nettype none
`include "aes128_ctr_payload_cipher_unit_assert.svh"
module acpc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_last
);
   `ACPC_ASSERT(a_one_in_flight, clock, reset, rsp_valid |-> !req_ready, "byte taken while result pending")
   `ACPC_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "ready held after accept")
   `ACPC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last)), "stalled beat changed")
   `ACPC_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "result beat right after reset")
endmodule

bind aes128_ctr_payload_cipher_unit acpc_checker u_acpc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_byte(rsp_out_byte),
   .rsp_out_last(rsp_out_last)
);
`default_nettype wire

@@ dv/tb_aes128_ctr_payload_cipher_unit.sv @@
// Self-checking testbench for the AES-128 CTR payload cipher unit.
`default_nettype none
module tb_aes128_ctr_payload_cipher_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // One payload beat as driven, plus an optional hand-typed expected byte.
   typedef struct packed {
      logic [7:0]  data;
      logic [7:0]  src;
      logic [15:0] seq;
      logic        last;
      logic        typed;     // 1: exp_byte below is the expected output
      logic [7:0]  exp_byte;
   } payload_row_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } cipher_beat_type;

   localparam int DIR_ROWS = 22;

   // Own copy of the AES S-box and round constants for the predictor.
   localparam logic [7:0] SB [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };
   localparam logic [7:0] RC [0:9] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // Directed rows. With everything zero after reset the counter block is all
   // zero, so the keystream is the well-known zero-key AES output 66 e9 4b d4 ...
   localparam payload_row_type DIR_TABLE [0:DIR_ROWS-1] = '{
      // one-byte frame straight after reset
      '{8'h00, 8'h00, 16'h0000, 1'b1, 1'b1, 8'h66},
      // new frame, block 0 again; later source/sequence must be ignored
      '{8'hff, 8'h00, 16'h0000, 1'b0, 1'b1, 8'h99},
      '{8'hff, 8'hab, 16'h1234, 1'b0, 1'b1, 8'h16},
      '{8'h00, 8'hff, 16'hffff, 1'b0, 1'b1, 8'h4b},
      '{8'h80, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'h01, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'h55, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'haa, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'h0f, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'hf0, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'hff, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      // byte 15 ends block 0; the next byte crosses into block 1
      '{8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'hff, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00},
      // frame with extreme source and sequence
      '{8'h00, 8'hff, 16'hffff, 1'b0, 1'b0, 8'h00},
      '{8'hff, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00},
      '{8'h5a, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00},
      // one-byte frame with nonzero source and sequence
      '{8'ha5, 8'h5a, 16'h8001, 1'b1, 1'b0, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic [7:0]  req_source_node = '0;
   logic [15:0] req_sequence_req = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // Side band that travels with each driven beat.
   logic        row_typed = 1'b0;
   logic [7:0]  row_exp = '0;

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          fail_count = 0;
   int          beat_count = 0;
   int          frame_count = 0;
   int          block_count = 0;

   // Predictor copy of configuration and frame state.
   logic [63:0]  m_key_hi = '0, m_key_lo = '0;
   logic [7:0]   m_net = '0;
   logic [23:0]  m_salt = '0;
   logic         m_in_frame = 1'b0;
   logic [3:0]   m_offset = '0;
   logic [23:0]  m_block = '0;
   logic [7:0]   m_src = '0;
   logic [15:0]  m_seq = '0;
   logic [127:0] m_keystream = '0;

   cipher_beat_type expected_beats[$];

   aes128_ctr_payload_cipher_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_source_node(req_source_node),
      .req_sequence_req(req_sequence_req), .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte), .rsp_out_last(rsp_out_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // FIPS-197 AES-128 encryption; byte 0 of key and block sit in bits 127:120.
   function automatic logic [127:0] aes128_encrypt(input logic [127:0] key,
                                                  input logic [127:0] blk);
      logic [7:0] st [16];
      logic [7:0] sh [16];
      logic [7:0] rk [16];
      logic [7:0] tw [4];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127-8*i -: 8];
         st[i] = blk[127-8*i -: 8] ^ rk[i];
      end
      for (int r = 1; r <= 10; r++) begin
         for (int i = 0; i < 16; i++) st[i] = SB[st[i]];
         for (int i = 0; i < 16; i++) sh[i] = st[((((i >> 2) + (i & 3)) & 3) << 2) | (i & 3)];
         st = sh;
         if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               st[4*c]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
               st[4*c+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
               st[4*c+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
               st[4*c+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
            end
         end
         // advance the round key on the fly
         tw[0] = SB[rk[13]] ^ RC[r-1];
         tw[1] = SB[rk[14]];
         tw[2] = SB[rk[15]];
         tw[3] = SB[rk[12]];
         for (int j = 0; j < 4; j++) begin
            rk[j]    = rk[j] ^ tw[j];
            rk[j+4]  = rk[j+4] ^ rk[j];
            rk[j+8]  = rk[j+8] ^ rk[j+4];
            rk[j+12] = rk[j+12] ^ rk[j+8];
         end
         for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
      return res;
   endfunction

   // Work out the output beat for one accepted payload beat and advance state.
   function automatic cipher_beat_type cipher_predict(input logic [7:0] data,
                                                      input logic [7:0] src,
                                                      input logic [15:0] seq,
                                                      input logic last);
      cipher_beat_type o;
      if (!m_in_frame) begin
         m_src = src;
         m_seq = seq;
         m_block = '0;
         m_offset = '0;
         m_in_frame = 1'b1;
      end
      if (m_offset == 4'd0) begin
         m_keystream = aes128_encrypt({m_key_hi, m_key_lo},
            {m_src, m_net, m_seq[7:0], m_seq[15:8], m_salt, 48'h0, m_block});
         block_count++;
      end
      o.out_byte = data ^ m_keystream[127-8*m_offset -: 8];
      o.out_last = last;
      if (last) begin
         m_in_frame = 1'b0;
         m_offset = '0;
         m_block = '0;
      end else begin
         m_offset = m_offset + 4'd1;
         if (m_offset == 4'd0) m_block = m_block + 24'd1;
      end
      return o;
   endfunction

   // Predict on every accepted input beat; check every accepted output beat.
   always @(posedge clock) begin
      cipher_beat_type exp_beat;
      if (!reset) begin
         if (req_valid && req_ready) begin
            exp_beat = cipher_predict(req_data_byte, req_source_node, req_sequence_req,
                                      req_last_byte);
            if (row_typed) exp_beat.out_byte = row_exp;
            expected_beats.push_back(exp_beat);
            beat_count++;
            if (req_last_byte) frame_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected output beat, actual byte %h last %b",
                        $time, rsp_out_byte, rsp_out_last);
               fail_count++;
            end else begin
               exp_beat = expected_beats.pop_front();
               if (rsp_out_byte !== exp_beat.out_byte) begin
                  $display("%0t: out_byte expected %h actual %h",
                           $time, exp_beat.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_out_last !== exp_beat.out_last) begin
                  $display("%0t: out_last expected %b actual %b",
                           $time, exp_beat.out_last, rsp_out_last);
                  fail_count++;
               end
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Drive one beat; hold valid and payload until it is accepted.
   task automatic send_beat(input payload_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= row.data;
      req_source_node  <= row.src;
      req_sequence_req <= row.seq;
      req_last_byte    <= row.last;
      row_typed        <= row.typed;
      row_exp          <= row.exp_byte;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every expected beat is back, then let the
   // block settle before anything is reconfigured.
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // Write all four registers back to back and mirror them in the predictor.
   task automatic load_config(input logic [63:0] khi, input logic [63:0] klo,
                              input logic [7:0] net, input logic [23:0] slt);
      logic [63:0] vals [4];
      int unsigned idx [4];
      vals = '{khi, klo, {56'h0, net}, {40'h0, slt}};
      idx  = '{acpc_pkg::CSR_KEY_HIGH, acpc_pkg::CSR_KEY_LOW,
               acpc_pkg::CSR_NETWORK_ID, acpc_pkg::CSR_SALT};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i][1:0];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      m_key_hi = khi;
      m_key_lo = klo;
      m_net    = net;
      m_salt   = slt;
   endtask

   // Random frames: mostly short, some past two blocks; last beat closes frame.
   task automatic random_frames(input int n_beats);
      payload_row_type row;
      int sent;
      int len;
      sent = 0;
      while (sent < n_beats) begin
         len = ($urandom_range(9) < 8) ? $urandom_range(1, 20) : $urandom_range(21, 40);
         for (int k = 0; k < len; k++) begin
            row.data     = 8'($urandom_range(255));
            row.src      = 8'($urandom_range(255));
            row.seq      = 16'($urandom_range(65535));
            row.last     = (k == len - 1);
            row.typed    = 1'b0;
            row.exp_byte = '0;
            send_beat(row);
         end
         sent += len;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 0: reset configuration, no idling, directed rows then random
      for (int i = 0; i < DIR_ROWS; i++) send_beat(DIR_TABLE[i]);
      random_frames(160);
      drain();

      // phase 1: all-ones configuration, sender idles
      load_config({64{1'b1}}, {64{1'b1}}, 8'hff, 24'hffffff);
      send_idle_pct = 46;
      random_frames(170);
      drain();

      // phase 2: random configuration, receiver stalls
      load_config({$urandom, $urandom}, {$urandom, $urandom},
                  8'($urandom_range(255)), 24'($urandom_range(24'hffffff)));
      send_idle_pct = 0;
      stall_pct = 46;
      random_frames(170);
      drain();

      // phase 3: zeros written explicitly, then another random key; both idle
      load_config('0, '0, 8'h00, 24'h000000);
      send_idle_pct = 21;
      stall_pct = 21;
      random_frames(80);
      drain();
      load_config({$urandom, $urandom}, {$urandom, $urandom},
                  8'($urandom_range(255)), 24'($urandom_range(24'hffffff)));
      random_frames(90);
      drain();

      $display("Covered %0d payload beats in %0d frames, %0d keystream blocks,",
               beat_count, frame_count, block_count);
      $display("over five key/network/salt settings and four idle/stall mixes.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("Timeout with %0d beats still expected", expected_beats.size());
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
